FILE: hdl/dtbm_pkg.sv
// ----------------------------------------------------------------------------
// dtbm_pkg: shared types and constants of the dual token bucket meter
// Field widths, operation and register codes, and the beat record that
// travels from the front queue to the back engine.
// ----------------------------------------------------------------------------
package dtbm_pkg;

    localparam int RATE_W  = 32;
    localparam int CAP_W   = 42;   // rate * 1000
    localparam int TOK_W   = 43;   // signed, -cap .. cap
    localparam int AMT_W   = 32;
    localparam int TIME_W  = 64;
    localparam int DLY_W   = 11;
    localparam int CNT_W   = 64;
    localparam int QUO_W   = 43;   // divider dividend / quotient width
    localparam int CFG_IDX_W = 2;

    localparam logic [9:0]  MILLI_PER_BYTE = 10'd1000;
    localparam logic [10:0] FULL_AFTER_MS  = 11'd2000;

    // floor(2^42 / 1000): whole bytes from milli-bytes by multiply and shift
    localparam logic [32:0] RECIP_1000 = 33'd4398046511;

    // operation codes on the input port
    localparam logic [2:0] OP_TAKE   = 3'd0;
    localparam logic [2:0] OP_CHARGE = 3'd1;
    localparam logic [2:0] OP_DELAY  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_DRAIN  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RX_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_RATE = 2'd1;

    typedef enum logic [2:0] {
        K_TAKE,
        K_CHARGE,
        K_DELAY,
        K_READ,
        K_DRAIN,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               dir;
        logic [AMT_W-1:0]   amount;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] idx;
        logic [RATE_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_ctl;

endpackage

FILE: hdl/dtbm_front.sv
// ----------------------------------------------------------------------------
// dtbm_front: input beat decode and two-entry queue
// Decodes the operation code and holds up to two beats for the back engine.
// ----------------------------------------------------------------------------
module dtbm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_operation,
    input  logic                   i_direction,
    input  logic [31:0]            i_amount,
    input  logic [63:0]            i_now_ms,
    output dtbm_pkg::t_item        o_item,
    output logic                   o_item_valid,
    input  logic                   i_item_pop
);
    import dtbm_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    t_kind       kind;
    logic        push;

    // operation decode
    always_comb begin
        unique case (i_operation)
            OP_TAKE:   kind = K_TAKE;
            OP_CHARGE: kind = K_CHARGE;
            OP_DELAY:  kind = K_DELAY;
            OP_READ:   kind = K_READ;
            OP_DRAIN:  kind = K_DRAIN;
            default:   kind = K_NONE;
        endcase
    end

    assign o_stall      = (r_count == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{kind: kind, dir: i_direction,
                                 amount: i_amount, now_ms: i_now_ms};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (i_item_pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(i_item_pop);
        end
    end

endmodule

FILE: hdl/dtbm_div.sv
// ----------------------------------------------------------------------------
// dtbm_div: restoring divider
// One quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
module dtbm_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtbm_pkg::t_div_ctl    i_ctl,
    output logic                  o_done,
    output logic [42:0]           o_quotient
);
    import dtbm_pkg::*;

    localparam logic [5:0] LAST = 6'(QUO_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [5:0]         r_cnt;
    logic [RATE_W-1:0]  r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [RATE_W-1:0]  r_div;
    logic [RATE_W:0]    rem_sh;
    logic [RATE_W:0]    rem_sub;
    logic               fits;

    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_ctl.dividend;
            r_rem <= '0;
            r_div <= i_ctl.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_rem <= fits ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/dtbm_back.sv
// ----------------------------------------------------------------------------
// dtbm_back: bucket state and execution engine
// Holds both directions' buckets and counters, runs one beat at a time
// through refill, charge and divide steps, and owns the result register.
// ----------------------------------------------------------------------------
module dtbm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtbm_pkg::t_cfg_wr     i_cfg,
    input  dtbm_pkg::t_item       i_item,
    input  logic                  i_item_valid,
    output logic                  o_item_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_granted,
    output logic [10:0]           o_delay_ms,
    output logic [63:0]           o_rx_total,
    output logic [63:0]           o_tx_total
);
    import dtbm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_USE  = 3'd3;
    localparam logic [2:0] S_CHG  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_QEST = 3'd6;
    localparam logic [2:0] S_FIX  = 3'd7;

    logic [2:0]          r_state;
    t_item               r_item;
    logic [QUO_W-1:0]    r_prod;
    logic [53:0]         r_plo;
    logic [53:0]         r_phi;
    logic [32:0]         r_qest;

    logic [RATE_W-1:0]   r_rate  [2];
    logic [CAP_W-1:0]    r_cap   [2];
    logic [TOK_W-1:0]    r_tok   [2];
    logic [TIME_W-1:0]   r_stamp [2];
    logic                r_pend  [2];
    logic [CNT_W-1:0]    r_cnt   [2];

    logic                r_out_valid;
    logic [AMT_W-1:0]    r_out_granted;
    logic [DLY_W-1:0]    r_out_delay;
    logic [CNT_W-1:0]    r_out_rx;
    logic [CNT_W-1:0]    r_out_tx;

    logic                dir;
    logic [RATE_W-1:0]   rate;
    logic [CAP_W-1:0]    cap;
    logic signed [TOK_W:0] tok44;
    logic signed [TOK_W:0] cap44;
    logic [TIME_W-1:0]   elapsed;
    logic                restamp;
    logic [RATE_W-1:0]   mul_a;
    logic [DLY_W-1:0]    mul_b;
    logic [QUO_W-1:0]    mul_p;
    logic [QUO_W-1:0]    cfg_cap;
    logic signed [TOK_W+1:0] sum_tok;
    logic signed [TOK_W:0] chg_lim;
    logic signed [TOK_W:0] need44;
    logic [QUO_W-1:0]    dly_dividend;
    logic [20:0]         tok_lo;
    logic [20:0]         tok_hi;
    logic [74:0]         rcp_sum;
    logic [QUO_W-1:0]    q_back;
    logic [QUO_W-1:0]    tok_rem;
    logic [32:0]         q_adj;
    t_div_ctl            div_ctl;
    logic                div_done;
    logic [QUO_W-1:0]    div_q;
    logic                start;

    assign dir     = r_item.dir;
    assign rate    = r_rate[dir];
    assign cap     = r_cap[dir];
    assign tok44   = $signed({r_tok[dir][TOK_W-1], r_tok[dir]});
    assign cap44   = $signed({2'b00, cap});
    assign elapsed = r_item.now_ms - r_stamp[dir];
    assign restamp = r_pend[dir] || (r_item.now_ms <= r_stamp[dir]);

    // one shared multiplier: refill credit or charge cost
    assign mul_a = (r_item.kind == K_CHARGE) ? r_item.amount : rate;
    assign mul_b = (r_item.kind == K_CHARGE) ? {1'b0, MILLI_PER_BYTE} : elapsed[DLY_W-1:0];
    assign mul_p = QUO_W'({11'b0, mul_a} * {32'b0, mul_b});

    // capacity of a newly written rate
    assign cfg_cap = QUO_W'({11'b0, i_cfg.data} * {33'b0, MILLI_PER_BYTE});

    assign sum_tok = $signed({tok44[TOK_W], tok44}) + $signed({2'b00, r_prod});
    assign chg_lim = $signed({1'b0, r_prod}) - cap44;
    assign need44  = $signed({34'b0, MILLI_PER_BYTE}) - tok44;
    assign dly_dividend = need44[QUO_W-1:0] + {11'b0, rate} - 43'd1;

    // whole bytes of a positive bucket: two partial products by 1/1000,
    // then one correction step since the estimate is low by at most one
    assign tok_lo  = r_tok[dir][20:0];
    assign tok_hi  = r_tok[dir][41:21];
    assign rcp_sum = {21'b0, r_plo} + {r_phi, 21'b0};
    assign q_back  = QUO_W'({10'b0, r_qest} * {33'b0, MILLI_PER_BYTE});
    assign tok_rem = r_tok[dir] - q_back;
    assign q_adj   = (tok_rem >= {33'b0, MILLI_PER_BYTE}) ? r_qest + 33'd1 : r_qest;

    // divider launch for a delay query
    always_comb begin
        div_ctl.start    = (r_state == S_USE) && (r_item.kind == K_DELAY) && (need44 > 0);
        div_ctl.dividend = dly_dividend;
        div_ctl.divisor  = rate;
    end

    dtbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign start      = (r_state == S_IDLE) && i_item_valid && !r_out_valid;
    assign o_item_pop = start;

    // engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_rate[i]  <= '0;
                r_cap[i]   <= '0;
                r_tok[i]   <= '0;
                r_stamp[i] <= '0;
                r_pend[i]  <= 1'b1;
                r_cnt[i]   <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;

            // rate write refills the bucket and re-stamps on next use
            if (i_cfg.valid && (i_cfg.idx == CFG_RX_RATE || i_cfg.idx == CFG_TX_RATE)) begin
                r_rate[i_cfg.idx[0]] <= i_cfg.data;
                r_cap[i_cfg.idx[0]]  <= cfg_cap[CAP_W-1:0];
                r_tok[i_cfg.idx[0]]  <= cfg_cap;
                r_pend[i_cfg.idx[0]] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item        <= i_item;
                        r_out_granted <= '0;
                        r_out_delay   <= '0;
                        r_out_rx      <= '0;
                        r_out_tx      <= '0;
                        r_state       <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    unique case (r_item.kind)
                        K_TAKE, K_DELAY: begin
                            if (rate == '0 || (r_item.kind == K_TAKE && r_item.amount == '0)) begin
                                if (r_item.kind == K_TAKE) r_out_granted <= r_item.amount;
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end else if (restamp) begin
                                r_pend[dir]  <= 1'b0;
                                r_stamp[dir] <= r_item.now_ms;
                                r_state      <= S_USE;
                            end else begin
                                r_stamp[dir] <= r_item.now_ms;
                                if (elapsed >= TIME_W'(FULL_AFTER_MS)) begin
                                    r_tok[dir] <= TOK_W'(cap);
                                    r_state    <= S_USE;
                                end else begin
                                    r_prod  <= mul_p;
                                    r_state <= S_ADD;
                                end
                            end
                        end
                        K_CHARGE: begin
                            r_cnt[dir] <= r_cnt[dir] + CNT_W'(r_item.amount);
                            if (rate != '0 && r_item.amount != '0) begin
                                r_prod  <= mul_p;
                                r_state <= S_CHG;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end
                        end
                        K_READ, K_DRAIN: begin
                            r_out_rx <= r_cnt[0];
                            r_out_tx <= r_cnt[1];
                            if (r_item.kind == K_DRAIN) begin
                                r_cnt[0] <= '0;
                                r_cnt[1] <= '0;
                            end
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                        default: begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    endcase
                end
                S_ADD: begin
                    // credit, clamped to capacity
                    r_tok[dir] <= (sum_tok > cap44) ? TOK_W'(cap) : sum_tok[TOK_W-1:0];
                    r_state    <= S_USE;
                end
                S_CHG: begin
                    // debit, floored at minus capacity
                    if (tok44 < chg_lim) r_tok[dir] <= TOK_W'(-cap44);
                    else r_tok[dir] <= TOK_W'(tok44 - $signed({1'b0, r_prod}));
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_USE: begin
                    if (div_ctl.start) begin
                        r_state <= S_DIV;
                    end else if (r_item.kind == K_TAKE && tok44 > 0) begin
                        r_plo   <= 54'({33'b0, tok_lo} * {21'b0, RECIP_1000});
                        r_phi   <= 54'({33'b0, tok_hi} * {21'b0, RECIP_1000});
                        r_state <= S_QEST;
                    end else begin
                        // bucket empty or in debt (take) or a byte already there (delay)
                        if (r_item.kind == K_DELAY) r_out_delay <= 11'd1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_QEST: begin
                    r_qest  <= rcp_sum[74:42];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_out_granted <= (q_adj >= {1'b0, r_item.amount}) ?
                                     r_item.amount : q_adj[AMT_W-1:0];
                    r_out_valid   <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_delay <= (div_q == '0) ? 11'd1 : div_q[DLY_W-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_granted  = r_out_granted;
    assign o_delay_ms = r_out_delay;
    assign o_rx_total = r_out_rx;
    assign o_tx_total = r_out_tx;

endmodule

FILE: hdl/dual_token_bucket_meter_unit.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_meter_unit: two-direction byte meter and rate limiter
// Front decode queue feeding the bucket engine with its result register.
// ----------------------------------------------------------------------------
// Each beat gives exactly one result. A two-beat queue takes input while the
// engine works; the engine handles one beat at a time and starts the next only
// once the result register has been taken. Read, drain, unknown operations,
// unlimited takes and charges without debit finish in the evaluate step, a
// debiting charge in the charge step; a limited take refills its bucket, ends
// there when the bucket is empty or in debt, and otherwise forms whole bytes by
// a multiply with 1/1000 and one correction step; a delay query refills and
// then runs the 43-step divider by the rate (one quotient bit per cycle) unless
// a byte is already there. Rate registers may be written at any idle time and
// are applied at once; the config port is always ready.
module dual_token_bucket_meter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [2:0]   i_operation,
    input  logic         i_direction,
    input  logic [31:0]  i_amount,
    input  logic [63:0]  i_now_ms,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_granted,
    output logic [10:0]  o_delay_ms,
    output logic [63:0]  o_rx_total,
    output logic [63:0]  o_tx_total,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import dtbm_pkg::*;

    t_item    item;
    logic     item_valid;
    logic     item_pop;
    t_cfg_wr  cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg = '{valid: i_cfg_valid, idx: i_cfg_index, data: i_cfg_data};

    dtbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_direction  (i_direction),
        .i_amount     (i_amount),
        .i_now_ms     (i_now_ms),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    dtbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_granted    (o_granted),
        .o_delay_ms   (o_delay_ms),
        .o_rx_total   (o_rx_total),
        .o_tx_total   (o_tx_total)
    );

endmodule

FILE: hdl/dtbm_checker.sv
// ----------------------------------------------------------------------------
// dtbm_checker: port-level checks for the meter
// Result shape and output handshake rules, bound to the top level.
// ----------------------------------------------------------------------------
module dtbm_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_valid,
    input  logic         i_stall,
    input  logic [31:0]  o_granted,
    input  logic [10:0]  o_delay_ms,
    input  logic [63:0]  o_rx_total,
    input  logic [63:0]  o_tx_total
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_granted) && $stable(o_delay_ms)
        && $stable(o_rx_total) && $stable(o_tx_total))
        else $error("stalled result changed");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // delay never above the long-idle bound
    a_dly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_delay_ms <= 11'd2000)
        else $error("delay out of range");

    // a grant belongs to a take only
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_granted != 32'd0 |-> o_delay_ms == 11'd0
        && o_rx_total == 64'd0 && o_tx_total == 64'd0)
        else $error("grant mixed with other fields");

    // a delay belongs to a delay query only
    a_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_delay_ms != 11'd0 |-> o_rx_total == 64'd0 && o_tx_total == 64'd0)
        else $error("delay mixed with totals");

endmodule

bind dual_token_bucket_meter_unit dtbm_checker u_dtbm_checker (.*);

FILE: dv/tb_dual_token_bucket_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_token_bucket_meter_unit: self-checking bench for the byte meter
// Drives take, charge, delay, read, drain and unused opcodes against both
// buckets under several rate settings. A scoreboard class keeps its own model
// of the buckets and counters and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_dual_token_bucket_meter_unit;
    import dtbm_pkg::*;

    localparam longint unsigned IDLE_LIMIT = 20000;
    localparam int              DRAIN_WAIT = 80;
    localparam logic [2:0]      OP_UNUSED  = 3'd7;

    // expected result of one input beat
    typedef struct {
        logic [31:0] granted;
        logic [10:0] delay_ms;
        logic [63:0] rx_total;
        logic [63:0] tx_total;
    } t_meter_result;

    // model of both buckets plus the queue of pending results
    class t_meter_scoreboard;
        longint unsigned rate[2];
        longint          tokens[2];
        longint unsigned stamp[2];
        bit              pending[2];
        longint unsigned bytes[2];
        t_meter_result   want_q[$];
        int              n_err;
        int              n_checked;

        function void reset_state();
            for (int i = 0; i < 2; i++) begin
                rate[i] = 0; tokens[i] = 0; stamp[i] = 0;
                pending[i] = 1; bytes[i] = 0;
            end
        endfunction

        function void write_rate(int d, logic [31:0] v);
            rate[d] = v;
            tokens[d] = longint'(rate[d]) * 1000;
            pending[d] = 1;
        endfunction

        // credit elapsed time to one bucket
        function void credit(int d, longint unsigned now);
            longint unsigned gap;
            longint cap;
            cap = longint'(rate[d]) * 1000;
            if (pending[d] || now <= stamp[d]) begin
                pending[d] = 0;
                stamp[d] = now;
                return;
            end
            gap = now - stamp[d];
            stamp[d] = now;
            if (gap >= 2000) begin
                tokens[d] = cap;
                return;
            end
            tokens[d] += longint'(rate[d]) * longint'(gap);
            if (tokens[d] > cap) tokens[d] = cap;
        endfunction

        function void note_input(logic [2:0] op, logic dir, logic [31:0] amt,
                                 logic [63:0] now);
            t_meter_result r;
            int d;
            longint unsigned avail;
            longint cap, cost, need;
            d = dir;
            r = '{32'd0, 11'd0, 64'd0, 64'd0};
            case (op)
                OP_TAKE: begin
                    if (rate[d] == 0 || amt == 0) r.granted = amt;
                    else begin
                        credit(d, now);
                        avail = (tokens[d] > 0) ? longint'(tokens[d]) / 1000 : 0;
                        r.granted = (avail < amt) ? avail : amt;
                    end
                end
                OP_CHARGE: begin
                    bytes[d] += amt;
                    if (rate[d] != 0 && amt != 0) begin
                        cap = longint'(rate[d]) * 1000;
                        cost = longint'({32'd0, amt}) * 1000;
                        if (tokens[d] < cost - cap) tokens[d] = -cap;
                        else tokens[d] -= cost;
                    end
                end
                OP_DELAY: begin
                    if (rate[d] != 0) begin
                        credit(d, now);
                        need = 1000 - tokens[d];
                        if (need <= 0) r.delay_ms = 1;
                        else begin
                            need = (need + longint'(rate[d]) - 1) / longint'(rate[d]);
                            r.delay_ms = (need < 1) ? 11'd1 : 11'(need);
                        end
                    end
                end
                OP_READ, OP_DRAIN: begin
                    r.rx_total = bytes[0];
                    r.tx_total = bytes[1];
                    if (op == OP_DRAIN) begin
                        bytes[0] = 0; bytes[1] = 0;
                    end
                end
                default: ;
            endcase
            want_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] g, logic [10:0] dl,
                                   logic [63:0] rx, logic [63:0] tx);
            t_meter_result w;
            n_checked++;
            if (want_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat g=%0d", g);
                return;
            end
            w = want_q.pop_front();
            if (w.granted !== g || w.delay_ms !== dl || w.rx_total !== rx ||
                w.tx_total !== tx) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp g=%0d d=%0d rx=%0d tx=%0d got g=%0d d=%0d rx=%0d tx=%0d",
                             w.granted, w.delay_ms, w.rx_total, w.tx_total,
                             g, dl, rx, tx);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_operation = '0;
    logic        i_direction = 0;
    logic [31:0] i_amount = '0;
    logic [63:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_granted;
    logic [10:0] o_delay_ms;
    logic [63:0] o_rx_total;
    logic [63:0] o_tx_total;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    t_meter_scoreboard sb = new();
    longint unsigned idle_cycles = 0;
    longint unsigned clock_ms[2];
    int              beats_sent = 0;
    int              stall_mode = 0;
    bit              timed_out = 0;

    dual_token_bucket_meter_unit dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_granted, o_delay_ms, o_rx_total, o_tx_total);
        case (stall_mode)
            0: i_stall <= 0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no progress");
            $display("** dual_token_bucket_meter_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_rate(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_rate(idx, v);
        i_cfg_valid <= 0;
    endtask

    // one input beat; holds valid until accepted
    task automatic send_beat(logic [2:0] op, logic dir, logic [31:0] amt,
                             logic [63:0] now);
        i_valid <= 1; i_operation <= op; i_direction <= dir;
        i_amount <= amt; i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(op, dir, amt, now);
        beats_sent++;
    endtask

    task automatic gap(int n);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for every result, then let the engine settle
    task automatic wait_idle();
        i_valid <= 0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic random_beat(int d_sel, int heavy_time);
        logic [2:0]  op;
        logic [31:0] amt;
        int          d;
        int          k;
        d = (d_sel < 0) ? $urandom_range(0, 1) : d_sel;
        k = $urandom_range(0, 99);
        op = (k < 30) ? OP_TAKE : (k < 55) ? OP_CHARGE : (k < 80) ? OP_DELAY :
             (k < 88) ? OP_READ : (k < 95) ? OP_DRAIN : 3'($urandom_range(5, 7));
        case ($urandom_range(0, 4))
            0: amt = $urandom_range(0, 20);
            1: amt = $urandom_range(0, 5000);
            2: amt = $urandom();
            3: amt = 32'hFFFF_FFFF;
            default: amt = $urandom_range(0, 500);
        endcase
        // time mostly creeps forward, sometimes jumps, stalls or goes back
        case ($urandom_range(0, 9))
            0: clock_ms[d] = clock_ms[d];
            1: clock_ms[d] = clock_ms[d] - $urandom_range(0, 50);
            2: clock_ms[d] = clock_ms[d] + $urandom_range(1999, 2001);
            3: if (heavy_time) clock_ms[d] = {$urandom(), $urandom()};
            default: clock_ms[d] = clock_ms[d] + $urandom_range(1, 40);
        endcase
        send_beat(op, d[0], amt, clock_ms[d]);
    endtask

    initial begin
        logic [31:0] rates [6];
        rates = '{32'd0, 32'd1, 32'd1000, 32'd123457, 32'hFFFF_FFFF, 32'd77};
        sb.reset_state();
        clock_ms[0] = 100; clock_ms[1] = 100;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: unlimited, then limited corners
        send_beat(OP_TAKE, 0, 32'hFFFF_FFFF, 64'd5);
        send_beat(OP_DELAY, 1, 32'd0, 64'd5);
        send_beat(OP_CHARGE, 0, 32'hFFFF_FFFF, 64'd0);
        send_beat(OP_CHARGE, 1, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_READ, 0, 32'd0, 64'd0);
        send_beat(OP_UNUSED, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_DRAIN, 0, 32'd0, 64'd0);
        send_beat(OP_READ, 1, 32'd0, 64'd0);
        wait_idle();
        write_rate(CFG_RX_RATE, 32'd1000);
        write_rate(CFG_TX_RATE, 32'hFFFF_FFFF);
        send_beat(OP_TAKE, 0, 32'd0, 64'd10);           // zero amount
        send_beat(OP_TAKE, 0, 32'd600, 64'd10);         // first read stamps
        send_beat(OP_CHARGE, 0, 32'd5000, 64'd0);       // debt clamps
        send_beat(OP_TAKE, 0, 32'd10, 64'd10);          // debt grants nothing
        send_beat(OP_DELAY, 0, 32'd0, 64'd9);           // clock went back
        send_beat(OP_DELAY, 0, 32'd0, 64'd2009);        // long idle fills
        send_beat(OP_TAKE, 0, 32'hFFFF_FFFF, 64'd2009); // stalled clock
        send_beat(OP_DELAY, 1, 32'd0, 64'd1);           // byte already there
        send_beat(OP_CHARGE, 1, 32'hFFFF_FFFF, 64'd0);
        send_beat(OP_DELAY, 1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_TAKE, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_DRAIN, 1, 32'd0, 64'd0);
        wait_idle();

        // random phases, each with its own rate pair
        for (int ph = 0; ph < 8; ph++) begin
            write_rate(CFG_RX_RATE, (ph < 6) ? rates[ph] : $urandom_range(1, 300));
            write_rate(CFG_TX_RATE, (ph < 6) ? rates[5 - ph] : $urandom());
            stall_mode = ph % 3;
            for (int n = 0; n < 105; ) begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 105; b++, n++)
                    random_beat(-1, (ph == 7));
                if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
            end
            wait_idle();
        end

        $display("covered %0d input beats and %0d result beats over 10 rate settings",
                 beats_sent, sb.n_checked);
        if (sb.n_err == 0 && sb.want_q.size() == 0)
            $display("** dual_token_bucket_meter_unit: PASSED **");
        else begin
            $display("%0d mismatches, %0d results missing", sb.n_err, sb.want_q.size());
            $display("** dual_token_bucket_meter_unit: FAILED **");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/dtbm_pkg.sv
hdl/dtbm_front.sv
hdl/dtbm_div.sv
hdl/dtbm_back.sv
hdl/dual_token_bucket_meter_unit.sv
hdl/dtbm_checker.sv
dv/tb_dual_token_bucket_meter_unit.sv
